/* rtl/core/icg_pkg.sv */
package icg_pkg;

  localparam int NUM_KEYS_DEF = 24;
  localparam int ADC_BITS_DEF = 12;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int SLIDER_CFG_W = 12;
  localparam int HOLD_W      = 16;
  localparam int TIME_W      = 32;
  localparam int VALUE_W     = 32;

  localparam logic [SLIDER_CFG_W-1:0] CENTER_RST    = 12'd750;
  localparam logic [SLIDER_CFG_W-1:0] DEAD_ZONE_RST = 12'd100;
  localparam logic [HOLD_W-1:0]       HOLD_RST      = 16'd300;

  localparam logic [VALUE_W-1:0] KEY_PRESS_FLAG = 32'h0000_0080;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLIDER_CENTER    = 2'd0,
    CFG_SLIDER_DEAD_ZONE = 2'd1,
    CFG_SLIDER_HOLD_MS   = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    EV_KEY    = 2'd0,
    EV_ENC0   = 2'd1,
    EV_ENC1   = 2'd2,
    EV_SLIDER = 2'd3
  } ev_kind_t;

  // Head of the key change shift register.
  typedef struct packed {
    logic chg;
    logic level;
    logic rest_zero;
    logic at_end;
  } key_stat_t;

  // Slider unit strobes.
  typedef struct packed {
    logic load;
    logic decide;
    logic commit;
  } sld_ctl_t;

endpackage

/* rtl/core/icg_if.sv */
interface icg_in_if #(
  parameter int NUM_KEYS = icg_pkg::NUM_KEYS_DEF,
  parameter int ADC_BITS = icg_pkg::ADC_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [NUM_KEYS-1:0]  key_levels;
  logic signed [31:0]   enc0_step;
  logic signed [31:0]   enc1_step;
  logic [ADC_BITS-1:0]  slider_sample;
  logic [31:0]          now_ms;

  modport source (output valid, key_levels, enc0_step, enc1_step, slider_sample, now_ms,
                  input ready);
  modport sink   (input valid, key_levels, enc0_step, enc1_step, slider_sample, now_ms,
                  output ready);
endinterface

interface icg_out_if;
  logic                valid;
  logic                ready;
  icg_pkg::ev_kind_t   event_kind;
  logic signed [31:0]  event_value;
  logic                last_event;

  modport source (output valid, event_kind, event_value, last_event, input ready);
  modport sink   (input valid, event_kind, event_value, last_event, output ready);
endinterface

/* rtl/core/icg_key_scan.sv */
module icg_key_scan #(
  parameter int NUM_KEYS = icg_pkg::NUM_KEYS_DEF,
  parameter int KW       = $clog2(NUM_KEYS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic                primed,
  input  logic                shift,
  input  logic [NUM_KEYS-1:0] keys,
  output icg_pkg::key_stat_t  stat,
  output logic [KW-1:0]       idx
);
  import icg_pkg::*;

  logic [NUM_KEYS-1:0] prev_r;
  logic [NUM_KEYS-1:0] chg_r;
  logic [NUM_KEYS-1:0] lvl_r;
  logic [KW-1:0]       cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '1;
      chg_r  <= '0;
      cnt_r  <= '0;
    end else if (load) begin
      prev_r <= keys;
      chg_r  <= primed ? (keys ^ prev_r) : '0;
      cnt_r  <= '0;
    end else if (shift) begin
      chg_r  <= chg_r >> 1;
      cnt_r  <= cnt_r + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lvl_r <= keys;
    end else if (shift) begin
      lvl_r <= lvl_r >> 1;
    end
  end

  assign stat.chg       = chg_r[0];
  assign stat.level     = lvl_r[0];
  assign stat.rest_zero = (chg_r[NUM_KEYS-1:1] == '0);
  assign stat.at_end    = (cnt_r == KW'(NUM_KEYS - 1));
  assign idx            = cnt_r;

endmodule

/* rtl/core/icg_slider.sv */
module icg_slider #(
  parameter int ADC_BITS = icg_pkg::ADC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  icg_pkg::sld_ctl_t                  ctl,
  input  logic [ADC_BITS-1:0]                sample,
  input  logic [icg_pkg::TIME_W-1:0]         now_ms,
  input  logic [icg_pkg::SLIDER_CFG_W-1:0]   center,
  input  logic [icg_pkg::SLIDER_CFG_W-1:0]   dead_zone,
  input  logic [icg_pkg::HOLD_W-1:0]         hold_ms,
  output logic                               hit,
  output logic [icg_pkg::VALUE_W-1:0]        diff_ext
);
  import icg_pkg::*;

  localparam int MW = (ADC_BITS > SLIDER_CFG_W) ? ADC_BITS : SLIDER_CFG_W;
  localparam int DW = MW + 1;

  logic [ADC_BITS-1:0] samp_r;
  logic [TIME_W-1:0]   now_r;
  logic [TIME_W-1:0]   last_r;
  logic                hit_r;
  logic [DW-1:0]       diff_r;

  logic [DW-1:0]       diff;
  logic [DW-1:0]       mag;
  logic [TIME_W-1:0]   elapsed;

  always_comb begin
    diff    = DW'(samp_r) - DW'(center);
    mag     = diff[DW-1] ? (~diff + DW'(1)) : diff;
    elapsed = now_r - last_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      samp_r <= sample;
      now_r  <= now_ms;
    end
    if (ctl.decide) begin
      diff_r <= diff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      hit_r  <= 1'b0;
    end else begin
      if (ctl.decide) begin
        hit_r <= (mag > DW'(dead_zone)) && (elapsed > TIME_W'(hold_ms));
      end
      if (ctl.commit) begin
        last_r <= now_r;
      end
    end
  end

  assign hit      = hit_r;
  assign diff_ext = {{(VALUE_W-DW){diff_r[DW-1]}}, diff_r};

endmodule

/* rtl/core/input_change_event_generator.sv */
// Channel | Dir | Payload                                              | Accept
// in_ch   | in  | key_levels, enc0/enc1_step, slider_sample, now_ms   | valid & ready
// out_ch  | out | event_kind, event_value, last_event                 | valid & ready
// cfg_*   | in  | cfg_idx selects register, cfg_wdata                  | cfg_we
//
// A scan latches its inputs, makes the slider decision, walks the change shift
// register one key bit at a time, then handles encoder zero, encoder one and the slider.
// The first scan after reset only records key levels.
// Synchronous active-low reset; no clearing pass. An output stall holds the
// sequencer on the event that waits; in_ch.ready rises once the sequencer is back
// to idle, while the final item may still wait at the output.
module input_change_event_generator #(
  parameter int NUM_KEYS = icg_pkg::NUM_KEYS_DEF,
  parameter int ADC_BITS = icg_pkg::ADC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  icg_in_if.sink                          in_ch,
  icg_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [icg_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [icg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import icg_pkg::*;

  localparam int KW = $clog2(NUM_KEYS);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_KEYS   = 6'b000100,
    S_ENC0   = 6'b001000,
    S_ENC1   = 6'b010000,
    S_SLIDE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [SLIDER_CFG_W-1:0] center_r;
  logic [SLIDER_CFG_W-1:0] dead_zone_r;
  logic [HOLD_W-1:0]       hold_r;
  logic                    primed_r;

  logic [VALUE_W-1:0] enc0_r, enc1_r;
  logic               enc0_nz_r, enc1_nz_r;

  logic               out_valid_r;
  ev_kind_t           out_kind_r;
  logic [VALUE_W-1:0] out_value_r;
  logic               out_last_r;

  logic               in_acc, out_free;
  logic               emit, e_last, key_shift;
  ev_kind_t           e_kind;
  logic [VALUE_W-1:0] e_value;

  key_stat_t          kst;
  logic [KW-1:0]      kidx;
  sld_ctl_t           sctl;
  logic               sld_hit;
  logic [VALUE_W-1:0] sld_diff;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Configuration registers; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r    <= CENTER_RST;
      dead_zone_r <= DEAD_ZONE_RST;
      hold_r      <= HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SLIDER_CENTER:    center_r    <= cfg_wdata[SLIDER_CFG_W-1:0];
        CFG_SLIDER_DEAD_ZONE: dead_zone_r <= cfg_wdata[SLIDER_CFG_W-1:0];
        CFG_SLIDER_HOLD_MS:   hold_r      <= cfg_wdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  icg_key_scan #(.NUM_KEYS(NUM_KEYS), .KW(KW)) u_keys (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (in_acc),
    .primed (primed_r),
    .shift  (key_shift),
    .keys   (in_ch.key_levels),
    .stat   (kst),
    .idx    (kidx)
  );

  icg_slider #(.ADC_BITS(ADC_BITS)) u_slider (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (sctl),
    .sample    (in_ch.slider_sample),
    .now_ms    (in_ch.now_ms),
    .center    (center_r),
    .dead_zone (dead_zone_r),
    .hold_ms   (hold_r),
    .hit       (sld_hit),
    .diff_ext  (sld_diff)
  );

  // Latch the encoder increments with the scan.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      enc0_r    <= in_ch.enc0_step;
      enc1_r    <= in_ch.enc1_step;
      enc0_nz_r <= (in_ch.enc0_step != '0);
      enc1_nz_r <= (in_ch.enc1_step != '0);
    end
  end

  // Sequencer: pick at most one event per cycle, hold while the output is full.
  always_comb begin
    state_nxt   = state_r;
    emit        = 1'b0;
    e_kind      = EV_KEY;
    e_value     = '0;
    e_last      = 1'b0;
    key_shift   = 1'b0;
    sctl.load   = in_acc && primed_r;
    sctl.decide = 1'b0;
    sctl.commit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && primed_r) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        sctl.decide = 1'b1;
        state_nxt   = S_KEYS;
      end
      S_KEYS: begin
        // A set change bit is a press when the new level is low.
        e_kind  = EV_KEY;
        e_value = VALUE_W'(kidx) | (kst.level ? '0 : KEY_PRESS_FLAG);
        e_last  = kst.rest_zero && !enc0_nz_r && !enc1_nz_r && !sld_hit;
        if (!kst.chg || out_free) begin
          emit      = kst.chg;
          key_shift = 1'b1;
          if (kst.at_end) state_nxt = S_ENC0;
        end
      end
      S_ENC0: begin
        e_kind  = EV_ENC0;
        e_value = enc0_r;
        e_last  = !enc1_nz_r && !sld_hit;
        if (!enc0_nz_r || out_free) begin
          emit      = enc0_nz_r;
          state_nxt = S_ENC1;
        end
      end
      S_ENC1: begin
        e_kind  = EV_ENC1;
        e_value = enc1_r;
        e_last  = !sld_hit;
        if (!enc1_nz_r || out_free) begin
          emit      = enc1_nz_r;
          state_nxt = S_SLIDE;
        end
      end
      S_SLIDE: begin
        e_kind  = EV_SLIDER;
        e_value = sld_diff;
        e_last  = 1'b1;
        if (!sld_hit || out_free) begin
          emit        = sld_hit;
          sctl.commit = sld_hit;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      primed_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) primed_r <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r  <= e_kind;
      out_value_r <= e_value;
      out_last_r  <= e_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.event_kind  = out_kind_r;
  assign out_ch.event_value = out_value_r;
  assign out_ch.last_event  = out_last_r;

endmodule

/* rtl/core/icg_checker.sv */
module icg_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input icg_pkg::ev_kind_t          out_kind,
  input logic [icg_pkg::VALUE_W-1:0] out_value,
  input logic                       out_last
);
  import icg_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_kind) && $stable(out_value) && $stable(out_last))
    else $error("stalled result changed");

  a_slider_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == EV_SLIDER) |-> out_last)
    else $error("slider event not marked last");

  a_key_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == EV_KEY) |-> (out_value[VALUE_W-1:8] == '0) &&
                                          (out_value[6] == 1'b0))
    else $error("key code out of range");

endmodule

bind input_change_event_generator icg_checker u_icg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.event_kind),
  .out_value (out_ch.event_value),
  .out_last  (out_ch.last_event)
);
